// File: sv/qrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_pkg
// types, constants and the microprogram of the quantized range random block
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int unsigned STEP_W  = 31;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned STATE_W = 48;
    localparam int unsigned MPLR_W  = 35;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned PC_W    = 4;
    localparam int unsigned CNT_W   = 6;

    localparam logic [MPLR_W-1:0]  LCG_MUL   = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD   = 48'd11;
    localparam logic [15:0]        SEED_LOW  = 16'h330E;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX  = 2'd2;

    // microprogram locations that are jump targets
    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_LCG    = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd3;
    localparam logic [PC_W-1:0] PC_MOD    = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL    = 4'd7;
    localparam logic [PC_W-1:0] PC_OUT    = 4'd9;
    localparam logic [PC_W-1:0] PC_LAST   = 4'd9;

    // iteration counts minus one
    localparam logic [CNT_W-1:0] CNT_LCG = 6'd34;
    localparam logic [CNT_W-1:0] CNT_DIV = 6'd31;
    localparam logic [CNT_W-1:0] CNT_MUL = 6'd30;
    localparam logic [CNT_W-1:0] CNT_NIL = 6'd0;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_START,
        UOP_MUL_STEP,
        UOP_LCG_FIN,
        UOP_DIV_STEP,
        UOP_DIV_FIN,
        UOP_MOD_FIN,
        UOP_MUL_FIN,
        UOP_OUT
    } t_uop;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_WAIT_IN,
        COND_CNT_NZ,
        COND_ERR,
        COND_QUO_ZERO,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop             op;
        logic             cnt_load;
        logic [CNT_W-1:0] cnt_init;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic err;
        logic quo_zero;
    } t_status;

    function automatic t_ctrl ucode_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            4'd0:    w = '{UOP_START,    1'b1, CNT_LCG, COND_WAIT_IN,  PC_IDLE};
            4'd1:    w = '{UOP_MUL_STEP, 1'b0, CNT_NIL, COND_CNT_NZ,   PC_LCG};
            4'd2:    w = '{UOP_LCG_FIN,  1'b1, CNT_DIV, COND_ERR,      PC_OUT};
            4'd3:    w = '{UOP_DIV_STEP, 1'b0, CNT_NIL, COND_CNT_NZ,   PC_DIV};
            4'd4:    w = '{UOP_DIV_FIN,  1'b1, CNT_DIV, COND_QUO_ZERO, PC_OUT};
            4'd5:    w = '{UOP_DIV_STEP, 1'b0, CNT_NIL, COND_CNT_NZ,   PC_MOD};
            4'd6:    w = '{UOP_MOD_FIN,  1'b1, CNT_MUL, COND_NONE,     PC_IDLE};
            4'd7:    w = '{UOP_MUL_STEP, 1'b0, CNT_NIL, COND_CNT_NZ,   PC_MUL};
            4'd8:    w = '{UOP_MUL_FIN,  1'b0, CNT_NIL, COND_NONE,     PC_IDLE};
            4'd9:    w = '{UOP_OUT,      1'b0, CNT_NIL, COND_OUT_BUSY, PC_OUT};
            default: w = '{UOP_NOP,      1'b0, CNT_NIL, COND_NONE,     PC_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: sv/qrr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_if
// valid/ready channels: request, result and configuration write
// ----------------------------------------------------------------------------
interface qrr_in_if;
    import qrr_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_size;
    modport source (output valid, output step_size, input ready);
    modport sink   (input valid, input step_size, output ready);
endinterface

interface qrr_out_if;
    import qrr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] random_value;
    logic                    range_error;
    modport source (output valid, output random_value, output range_error, input ready);
    modport sink   (input valid, input random_value, input range_error, output ready);
endinterface

interface qrr_cfg_if;
    import qrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/qrr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_seq
// microcode sequencer: step counter, loop counter and conditional jumps
// ----------------------------------------------------------------------------
module qrr_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_fire,
    input  wire logic             i_out_busy,
    input  wire qrr_pkg::t_status i_status,
    output qrr_pkg::t_ctrl        o_ctrl
);
    import qrr_pkg::*;

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_ctrl            w_ctrl;
    logic             w_jump;

    assign w_ctrl = ucode_rom(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.cond)
            COND_NONE:     w_jump = 1'b0;
            COND_WAIT_IN:  w_jump = !i_in_fire;
            COND_CNT_NZ:   w_jump = (r_cnt != '0);
            COND_ERR:      w_jump = i_status.err;
            COND_QUO_ZERO: w_jump = i_status.quo_zero;
            COND_OUT_BUSY: w_jump = i_out_busy;
            default:       w_jump = 1'b0;
        endcase

        if (w_jump) begin
            n_pc = w_ctrl.target;
        end else if (r_pc == PC_LAST) begin
            n_pc = PC_IDLE;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end

        if (w_ctrl.cnt_load) begin
            n_cnt = w_ctrl.cnt_init;
        end else if (w_ctrl.cond == COND_CNT_NZ && r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_LAST)
        else $error("step counter beyond program end");

    a_loop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.cond == COND_CNT_NZ && r_cnt == '0) |=> (r_pc == $past(r_pc) + PC_W'(1)))
        else $error("loop did not exit when its counter ran out");

endmodule
`default_nettype wire

// File: sv/qrr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrr_dp
// shared shift-add / shift-subtract datapath driven by the control word
// ----------------------------------------------------------------------------
module qrr_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire qrr_pkg::t_ctrl                   i_ctrl,
    input  wire logic                             i_in_fire,
    input  wire logic [qrr_pkg::STEP_W-1:0]       i_step_size,
    input  wire logic signed [qrr_pkg::VAL_W-1:0] i_min,
    input  wire logic signed [qrr_pkg::VAL_W-1:0] i_max,
    input  wire logic                             i_seed_load,
    input  wire logic [qrr_pkg::VAL_W-1:0]        i_seed,
    output qrr_pkg::t_status                      o_status,
    output logic signed [qrr_pkg::VAL_W-1:0]      o_result
);
    import qrr_pkg::*;

    logic [STATE_W-1:0]      r_state;
    logic [STEP_W-1:0]       r_stored;
    logic [STEP_W-1:0]       r_step;
    logic                    r_err;
    logic [VAL_W-1:0]        r_range;
    logic [STEP_W-1:0]       r_draw;
    logic [STATE_W-1:0]      r_acc;
    logic [STATE_W-1:0]      r_mcand;
    logic [MPLR_W-1:0]       r_mplier;
    logic [VAL_W-1:0]        r_quo;
    logic [VAL_W-1:0]        r_rem;
    logic [VAL_W-1:0]        r_dsr;
    logic signed [VAL_W-1:0] r_result;

    logic [STEP_W-1:0]  w_step_eff;
    logic [STATE_W-1:0] w_lcg_sum;
    logic [VAL_W:0]     w_shifted;
    logic [VAL_W+1:0]   w_diff;
    logic [VAL_W:0]     w_span;

    assign w_step_eff = (i_step_size != '0) ? i_step_size : r_stored;
    assign w_lcg_sum  = r_acc + LCG_ADD;
    assign w_shifted  = {r_rem, r_quo[VAL_W-1]};
    assign w_diff     = {1'b0, w_shifted} - {2'b00, r_dsr};
    // full-width span, never wraps
    assign w_span     = {i_max[VAL_W-1], i_max} - {i_min[VAL_W-1], i_min};

    assign o_status = '{err: r_err, quo_zero: (r_quo == '0)};
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= {STATE_W'(0)} | STATE_W'(SEED_LOW);
            r_stored <= STEP_W'(1);
            r_err    <= 1'b0;
        end else begin
            case (i_ctrl.op)
                UOP_START: begin
                    if (i_in_fire) begin
                        r_stored <= w_step_eff;
                        r_err    <= (i_min > i_max);
                    end
                end
                UOP_LCG_FIN: begin
                    r_state <= w_lcg_sum;
                end
                default: begin
                end
            endcase
            if (i_seed_load) begin
                r_state <= {i_seed, SEED_LOW};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            UOP_START: begin
                if (i_in_fire) begin
                    r_step   <= w_step_eff;
                    r_range  <= w_span[VAL_W-1:0];
                    r_result <= i_min;
                    r_acc    <= '0;
                    r_mcand  <= r_state;
                    r_mplier <= LCG_MUL;
                end
            end
            UOP_MUL_STEP: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[STATE_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[MPLR_W-1:1]};
            end
            UOP_LCG_FIN: begin
                r_draw <= w_lcg_sum[STATE_W-1 -: STEP_W];
                r_rem  <= '0;
                r_quo  <= r_range;
                r_dsr  <= {1'b0, r_step};
            end
            UOP_DIV_STEP: begin
                // restoring divide, one quotient bit per step
                if (!w_diff[VAL_W+1]) begin
                    r_rem <= w_diff[VAL_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shifted[VAL_W-1:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b0};
                end
            end
            UOP_DIV_FIN: begin
                r_dsr <= r_quo;
                r_quo <= {1'b0, r_draw};
                r_rem <= '0;
            end
            UOP_MOD_FIN: begin
                r_acc    <= '0;
                r_mcand  <= {{(STATE_W-VAL_W){1'b0}}, r_rem};
                r_mplier <= {{(MPLR_W-STEP_W){1'b0}}, r_step};
            end
            UOP_MUL_FIN: begin
                r_result <= i_min + $signed(r_acc[VAL_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored != '0)
        else $error("stored step became zero");

    a_err_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == UOP_OUT && r_err) |-> (r_result == i_min))
        else $error("inverted range result is not the lower bound");

endmodule
`default_nettype wire

// File: sv/quantized_range_random_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_range_random_top
// rand48 generator with range reduction to a quantized value in [min, max]
// ----------------------------------------------------------------------------
// One item in, one item out. Each request advances the 48-bit rand48 state,
// takes the 31-bit draw from bits 47..17 and returns
// min + (draw mod ((max-min)/step)) * step, or min when that quotient is zero.
// A nonzero step_size replaces the stored step (reset value 1), a zero one
// reuses it. min above max returns min with range_error set. The work is one
// shared shift-add / restoring-divide datapath run by a ten-word microprogram,
// one bit per cycle through the generator multiply, the range divide, the
// modulo and the final product, with setup steps between them; an inverted
// range or one narrower than one step skips the later loops. A new request is
// taken only when the sequencer is back at its idle step, which it reaches in
// the cycle the result appears, so one item is done before the next is taken;
// the result register lets the next request in while the last result still
// waits, and a result that is still waiting when the next one is done holds
// the sequencer at its output step.
// Config writes are accepted in any cycle and belong between items, with no
// item in flight; a write to seed_value reloads the state with
// (seed << 16) | 0x330E.
module quantized_range_random_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qrr_in_if.sink    i_req,
    qrr_out_if.source o_rsp,
    qrr_cfg_if.sink   i_cfg
);
    import qrr_pkg::*;

    // configuration registers
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;

    // result register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_err;

    t_ctrl                   w_ctrl;
    t_status                 w_status;
    logic                    w_in_fire;
    logic                    w_cfg_fire;
    logic                    w_out_busy;
    logic                    w_seed_load;
    logic signed [VAL_W-1:0] w_result;

    // requests taken only at the idle step
    assign i_req.ready = (w_ctrl.op == UOP_START);
    assign w_in_fire   = i_req.valid && i_req.ready;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign w_seed_load = w_cfg_fire && (i_cfg.index == REG_SEED);

    // result register stays full until the sink takes it
    assign w_out_busy = r_out_valid && !o_rsp.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out_value;
    assign o_rsp.range_error  = r_out_err;

    qrr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_busy (w_out_busy),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    qrr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in_fire   (w_in_fire),
        .i_step_size (i_req.step_size),
        .i_min       (r_min),
        .i_max       (r_max),
        .i_seed_load (w_seed_load),
        .i_seed      (i_cfg.data),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    // config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (w_cfg_fire) begin
            case (i_cfg.index)
                REG_MIN: r_min <= $signed(i_cfg.data);
                REG_MAX: r_max <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    // hand the finished item to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.op == UOP_OUT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == UOP_OUT && !w_out_busy) begin
            r_out_value <= w_result;
            r_out_err   <= w_status.err;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_req.ready)
        else $error("request accepted while an item was still in work");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the quantized range random block
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and presented by a
// falling-edge driver. A rising-edge monitor predicts each accepted
// request: it steps its own rand48 state and applies the same range
// quantization. Each returned item is then checked against the oldest
// prediction. Configuration writes only go out while nothing is in flight.
// The run has a directed part (range and step extremes, inverted range,
// zero step, seed reload, a write to the unused index) and then random
// phases. Each random phase picks a new range, sometimes a new seed, and
// a mix of step sizes.
// ----------------------------------------------------------------------------
module tb_top;
    import qrr_pkg::*;

    // own copy of the generator constants, kept apart from the design's
    localparam logic [STATE_W-1:0] RAND48_MUL = 48'h0005DEECE66D;
    localparam logic [STATE_W-1:0] RAND48_ADD = 48'd11;
    localparam logic [15:0]        SEED_TAIL  = 16'h330E;

    // index with no register behind it, writes there must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES  = 700;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASES       = 28;
    localparam int PHASE_ITEMS  = 62;

    typedef struct packed {
        logic signed [VAL_W-1:0] random_value;
        logic                    range_error;
    } t_quant_result;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    qrr_in_if  req_if ();
    qrr_out_if rsp_if ();
    qrr_cfg_if cfg_if ();

    quantized_range_random_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // predictor state, mirrors the block after reset
    logic [STATE_W-1:0]      lcg_state = {32'h0, SEED_TAIL};
    logic [STEP_W-1:0]       held_step = STEP_W'(1);
    logic signed [VAL_W-1:0] min_reg   = '0;
    logic signed [VAL_W-1:0] max_reg   = '0;

    logic [STEP_W-1:0] pending_steps[$];
    t_reg_write        pending_writes[$];
    t_quant_result     expected_draws[$];

    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;

    int idle_pct       = 37;
    int hold_ask       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    t_quant_result want;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("quantized_range_random_top regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch at %0t: %s got %h exp %h", $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    // one rand48 step, then quantize the draw into [min, max]
    function automatic t_quant_result draw_quantized(input logic [STEP_W-1:0] step_in);
        logic [STEP_W-1:0] draw;
        logic [STEP_W-1:0] step;
        longint            lo;
        longint            hi;
        longint unsigned   span;
        longint unsigned   divisions;
        t_quant_result     r;
        lcg_state = lcg_state * RAND48_MUL + RAND48_ADD;
        draw      = lcg_state[47:17];
        // zero step keeps the previous one
        if (step_in != '0)
            held_step = step_in;
        step = held_step;
        lo   = min_reg;
        hi   = max_reg;
        r.random_value = min_reg;
        r.range_error  = 1'b0;
        if (lo > hi) begin
            r.range_error = 1'b1;
        end else begin
            // full-width span, no wrap even for the widest range
            span      = hi - lo;
            divisions = span / step;
            if (divisions != 0)
                r.random_value = VAL_W'(lo + (draw % divisions) * step);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: sample every handshake at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken <= req_if.valid && req_if.ready;
        cfg_taken <= cfg_if.valid && cfg_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_SEED: lcg_state = {cfg_if.data, SEED_TAIL};
                    REG_MIN:  min_reg   = cfg_if.data;
                    REG_MAX:  max_reg   = cfg_if.data;
                    default:  ;
                endcase
            end
            if (req_if.valid && req_if.ready)
                expected_draws.push_back(draw_quantized(req_if.step_size));
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("unexpected item", {rsp_if.random_value,
                                    31'b0, rsp_if.range_error}, '0);
                end else begin
                    want = expected_draws.pop_front();
                    if (rsp_if.random_value !== want.random_value)
                        report_mismatch("random_value", 64'(rsp_if.random_value),
                                        64'(want.random_value));
                    if (rsp_if.range_error !== want.range_error)
                        report_mismatch("range_error", 64'(rsp_if.range_error),
                                        64'(want.range_error));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request driver: falling edge, valid held until the item is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (req_taken)
            pending_steps.delete(0);
        if (req_if.valid && !req_taken) begin
            req_if.valid <= 1'b1;
        end else if (i_rst_n && pending_steps.size() != 0
                     && $urandom_range(0, 99) >= idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.step_size <= pending_steps[0];
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // config driver, same scheme without gaps
    always @(negedge i_clk) begin
        if (cfg_taken)
            pending_writes.delete(0);
        if (cfg_if.valid && !cfg_taken) begin
            cfg_if.valid <= 1'b1;
        end else if (i_rst_n && pending_writes.size() != 0) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= pending_writes[0].index;
            cfg_if.data  <= pending_writes[0].data;
        end else begin
            cfg_if.valid <= 1'b0;
        end
    end

    // result ready: random gaps, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen    <= hold_ask;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
        t_reg_write w;
        w.index = idx;
        w.data  = value;
        pending_writes.push_back(w);
    endtask

    // wait until the block is idle with nothing outstanding on any channel
    task automatic settle();
        while (pending_steps.size() != 0 || pending_writes.size() != 0
               || expected_draws.size() != 0 || req_if.valid || cfg_if.valid)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                      phase;
        int                      n;
        logic signed [VAL_W-1:0] lo_pick;
        logic signed [VAL_W-1:0] hi_pick;
        longint                  tmp;
        longint                  span;
        longint                  shifted;
        logic [STEP_W-1:0]       step_pick;

        // every input known from time zero
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.step_size = '0;
        rsp_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_SEED;
        cfg_if.data      = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: zero-width range (min = max = 0), stored step of one
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'd1);
        settle();

        // small symmetric range, step reuse, step wider than the range
        queue_write(REG_SEED, 32'h12345678);
        queue_write(REG_MIN, -32'sd100);
        queue_write(REG_MAX, 32'sd100);
        queue_write(REG_UNUSED, 32'hDEADBEEF);
        settle();
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'd7);
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'd200);
        pending_steps.push_back(31'h7FFFFFFF);
        pending_steps.push_back(31'd3);
        settle();

        // widest range, all-ones seed
        queue_write(REG_SEED, 32'hFFFFFFFF);
        queue_write(REG_MIN, 32'h80000000);
        queue_write(REG_MAX, 32'h7FFFFFFF);
        settle();
        pending_steps.push_back(31'd1);
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'h7FFFFFFF);
        pending_steps.push_back(31'h40000000);
        pending_steps.push_back(31'd2);
        pending_steps.push_back(31'h55555555);
        settle();

        // inverted range, generator must carry on without a reseed
        queue_write(REG_MIN, 32'sd5);
        queue_write(REG_MAX, -32'sd5);
        settle();
        pending_steps.push_back(31'd9);
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'h2AAAAAAA);
        settle();

        // most inverted range possible
        queue_write(REG_MIN, 32'h7FFFFFFF);
        queue_write(REG_MAX, 32'h80000000);
        settle();
        pending_steps.push_back(31'd0);
        pending_steps.push_back(31'd1);
        settle();

        // single-point range
        queue_write(REG_SEED, 32'h80000000);
        queue_write(REG_MIN, 32'sd42);
        queue_write(REG_MAX, 32'sd42);
        settle();
        pending_steps.push_back(31'd1);
        pending_steps.push_back(31'd0);
        settle();

        // full positive range
        queue_write(REG_SEED, 32'h7FFFFFFF);
        queue_write(REG_MIN, 32'sd0);
        queue_write(REG_MAX, 32'h7FFFFFFF);
        settle();
        pending_steps.push_back(31'd1);
        pending_steps.push_back(31'd5);
        pending_steps.push_back(31'd0);
        settle();

        // random phases, block drained before each new setting
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo_pick = $urandom;
                    hi_pick = $urandom;
                end
                1: begin
                    lo_pick = $urandom;
                    tmp     = longint'(lo_pick) + longint'($urandom_range(0, 5000));
                    hi_pick = (tmp > 64'sd2147483647) ? 32'sh7FFFFFFF : tmp[31:0];
                end
                2: begin
                    lo_pick = 32'sh80000000;
                    hi_pick = 32'sh7FFFFFFF;
                end
                3: begin
                    lo_pick = $urandom;
                    hi_pick = lo_pick;
                end
                4: begin
                    // inverted
                    lo_pick = $urandom;
                    hi_pick = $urandom;
                    if (hi_pick > lo_pick) begin
                        tmp     = lo_pick;
                        lo_pick = hi_pick;
                        hi_pick = tmp[31:0];
                    end
                end
                default: begin
                    lo_pick = -int'($urandom_range(0, 1000));
                    hi_pick = $urandom_range(0, 32'h7FFFFFFF);
                end
            endcase

            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0:       queue_write(REG_SEED, 32'h0);
                    1:       queue_write(REG_SEED, 32'hFFFFFFFF);
                    default: queue_write(REG_SEED, $urandom);
                endcase
            end
            if (phase == 0 || $urandom_range(0, 4) != 0)
                queue_write(REG_MIN, lo_pick);
            if (phase == 0 || $urandom_range(0, 4) != 0)
                queue_write(REG_MAX, hi_pick);
            if ($urandom_range(0, 7) == 0)
                queue_write(REG_UNUSED, $urandom);
            settle();

            // one long stretch without gaps on either side
            idle_pct = (phase == 5) ? 0 : 37;
            // receiver backs off while requests keep coming
            if (phase == 9)
                hold_ask++;

            span = (max_reg >= min_reg) ? longint'(max_reg) - longint'(min_reg) : 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 3))
                    0: step_pick = '0;
                    1: step_pick = STEP_W'($urandom_range(1, 16));
                    2: begin
                        // steps scaled to the range give many divisions
                        shifted = span >>> $urandom_range(0, 31);
                        if (shifted == 0)
                            step_pick = 31'd1;
                        else if (shifted > 64'sh7FFFFFFF)
                            step_pick = 31'h7FFFFFFF;
                        else
                            step_pick = shifted[30:0];
                    end
                    default: step_pick = STEP_W'($urandom);
                endcase
                pending_steps.push_back(step_pick);
            end
            settle();
        end

        idle_pct = 37;
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_draws.size() != 0)
            report_mismatch("items never returned", 64'(expected_draws.size()), '0);

        if (mismatch_count == 0)
            $display("quantized_range_random_top regression: pass");
        else
            $display("quantized_range_random_top regression: fail");
        $finish;
    end

endmodule
